### hw/rtl/iiba_pkg.sv
// shared types and constants for the integral image box average core
`default_nettype none
package iiba_pkg;
   localparam int MaxCols = 256;
   localparam int MaxRows = 256;
   localparam int ColBits = 8;
   localparam int RowBits = 8;
   localparam int AddrBits = RowBits + ColBits;
   localparam int SumBits = 24;
   localparam int DivBits = 32;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_NO_IMAGE = 2'd1;
   localparam logic [1:0] STATUS_OUTSIDE = 2'd2;
   localparam logic [1:0] STATUS_ZERO_AREA = 2'd3;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // datapath commands from controller
   typedef struct packed {
      logic capture;    // latch input item and decode
      logic rd_en;      // issue a table read
      logic [1:0] rd_sel; // which corner
      logic acc_en;     // accumulate read data
      logic [1:0] acc_sel;
      logic load_wr;    // write the load entry
      logic div_start;
      logic out_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic is_query;
      logic query_err;
      logic load_skip;
      logic need_r1;
      logic need_r2;
      logic need_r3;
      logic div_done;
   } dp_status_type;
endpackage
`default_nettype wire

### hw/rtl/iiba_ram.sv
// generic single port ram with registered read
`default_nettype none
module iiba_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic rd_en,
   input wire logic [$clog2(Depth)-1:0] addr,
   input wire logic [Width-1:0] wdata,
   output logic [Width-1:0] rdata
);
   logic [Width-1:0] mem_ff [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wdata;
      end
      if (rd_en) begin
         rdata <= mem_ff[addr];
      end
   end
endmodule
`default_nettype wire

### hw/rtl/iiba_datapath.sv
// table, load position, corner accumulation and divider
`default_nettype none
module iiba_datapath import iiba_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire ctl_cmd_type cmd,
   output dp_status_type stat,
   input wire logic [57:0] item,
   input wire logic cfg_wr,
   input wire logic [8:0] cfg_data,
   output logic [8:0] row_length,
   output logic [23:0] out_avg,
   output logic [23:0] out_sum,
   output logic [1:0] out_status
);
   logic [8:0] row_length_ff;
   logic [8:0] eff_len;
   logic [15:0] run_ff, run_in;
   logic [RowBits:0] lrow_ff;
   logic [ColBits-1:0] lcol_ff;
   logic img_ff;
   logic op_ff, first_ff;
   logic [7:0] pix_ff, sr_ff, sc_ff, er_ff, ec_ff, rw_ff, rh_ff;
   logic [1:0] status_ff, status_in;
   logic [SumBits-1:0] acc_ff, acc_in, rdata;
   logic [AddrBits-1:0] addr;
   logic [RowBits:0] cur_row;
   logic [ColBits-1:0] cur_col;
   logic [15:0] area_ff;
   logic [DivBits-1:0] rem_ff, quo_ff;
   logic [5:0] dcnt_ff;
   logic dbusy_ff;
   logic [DivBits:0] trial;
   logic [DivBits-1:0] rem_sh;
   logic [23:0] avg_ff, sum_ff;
   logic [1:0] ost_ff;
   logic skip;

   assign row_length = row_length_ff;
   always_comb begin
      if (row_length_ff == 9'd0) begin
         eff_len = 9'd1;
      end else if (row_length_ff > 9'(MaxCols)) begin
         eff_len = 9'(MaxCols);
      end else begin
         eff_len = row_length_ff;
      end
   end

   // position after an optional restart
   assign cur_row = first_ff ? '0 : lrow_ff;
   assign cur_col = first_ff ? '0 : lcol_ff;
   assign skip = cur_row >= (RowBits+1)'(MaxRows) || {1'b0, cur_col} >= eff_len;

   // capture item
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= item[0];
         first_ff <= item[1];
         pix_ff <= item[9:2];
         sr_ff <= item[17:10];
         sc_ff <= item[25:18];
         er_ff <= item[33:26];
         ec_ff <= item[41:34];
         rw_ff <= item[49:42];
         rh_ff <= item[57:50];
      end
      area_ff <= 16'(rw_ff) * 16'(rh_ff);
   end

   // query status check
   always_comb begin
      if (!img_ff) begin
         status_in = STATUS_NO_IMAGE;
      end else if (sr_ff > er_ff || sc_ff > ec_ff || {1'b0, ec_ff} >= eff_len ||
                   !({1'b0, er_ff} < lrow_ff ||
                     ({1'b0, er_ff} == lrow_ff && ec_ff < lcol_ff))) begin
         status_in = STATUS_OUTSIDE;
      end else if (rw_ff == 8'd0 || rh_ff == 8'd0) begin
         status_in = STATUS_ZERO_AREA;
      end else begin
         status_in = STATUS_OK;
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.rd_en && cmd.rd_sel == 2'd0) begin
         status_ff <= status_in;
      end
   end

   assign stat.is_query = op_ff;
   assign stat.query_err = status_in != STATUS_OK;
   assign stat.load_skip = skip;
   assign stat.need_r1 = sr_ff != 8'd0;
   assign stat.need_r2 = sc_ff != 8'd0;
   assign stat.need_r3 = sr_ff != 8'd0 && sc_ff != 8'd0;
   assign stat.div_done = !dbusy_ff;

   // table address: corners for a query, entry above for a load read, own entry for the load write
   always_comb begin
      if (cmd.load_wr) begin
         addr = {cur_row[RowBits-1:0], cur_col};
      end else if (!op_ff) begin
         addr = {cur_row[RowBits-1:0] - 8'd1, cur_col};
      end else begin
         case (cmd.rd_sel)
            2'd0: addr = {er_ff, ec_ff};
            2'd1: addr = {sr_ff - 8'd1, ec_ff};
            2'd2: addr = {er_ff, sc_ff - 8'd1};
            default: addr = {sr_ff - 8'd1, sc_ff - 8'd1};
         endcase
      end
   end

   assign run_in = ((cur_col == '0) ? 16'd0 : run_ff) + 16'(pix_ff);

   iiba_ram #(.Width(SumBits), .Depth(MaxRows * MaxCols)) u_table (
      .clock(clock), .wr_en(cmd.load_wr), .rd_en(cmd.rd_en), .addr(addr),
      .wdata(24'(run_in) + ((cur_row == '0) ? 24'd0 : rdata)), .rdata(rdata)
   );

   // load position and image state
   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= 9'd256;
         run_ff <= '0;
         lrow_ff <= '0;
         lcol_ff <= '0;
         img_ff <= 1'b0;
      end else if (cfg_wr) begin
         row_length_ff <= cfg_data;
         run_ff <= '0;
         lrow_ff <= '0;
         lcol_ff <= '0;
         img_ff <= 1'b0;
      end else if (cmd.load_wr) begin
         run_ff <= run_in;
         img_ff <= 1'b1;
         if ({1'b0, cur_col} + 9'd1 >= eff_len) begin
            lcol_ff <= '0;
            lrow_ff <= cur_row + 1'b1;
         end else begin
            lcol_ff <= cur_col + 1'b1;
            lrow_ff <= cur_row;
         end
      end else if (cmd.acc_en && !op_ff && first_ff) begin
         // skipped load with restart still moves to origin
         run_ff <= '0;
         lrow_ff <= '0;
         lcol_ff <= '0;
      end
   end

   // corner accumulation
   always_comb begin
      acc_in = acc_ff;
      if (cmd.acc_en && op_ff) begin
         case (cmd.acc_sel)
            2'd0: acc_in = rdata;
            2'd3: acc_in = acc_ff + rdata;
            default: acc_in = acc_ff - rdata;
         endcase
      end
   end
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // restoring divider, one quotient bit per cycle
   assign rem_sh = {rem_ff[DivBits-2:0], quo_ff[DivBits-1]};
   assign trial = {1'b0, rem_sh} - {17'd0, area_ff};
   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0;
         dcnt_ff <= '0;
      end else if (cmd.div_start) begin
         dbusy_ff <= status_ff == STATUS_OK;
         dcnt_ff <= 6'd32;
         rem_ff <= '0;
         quo_ff <= {acc_in, 8'd0};
      end else if (dbusy_ff) begin
         if (!trial[DivBits]) begin
            rem_ff <= trial[DivBits-1:0];
            quo_ff <= {quo_ff[DivBits-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[DivBits-2:0], 1'b0};
         end
         dcnt_ff <= dcnt_ff - 6'd1;
         if (dcnt_ff == 6'd1) begin
            dbusy_ff <= 1'b0;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         ost_ff <= status_ff;
         if (status_ff == STATUS_OK) begin
            sum_ff <= acc_ff;
            avg_ff <= (quo_ff[31:24] != 8'd0) ? 24'hFFFFFF : quo_ff[23:0];
         end else begin
            sum_ff <= '0;
            avg_ff <= '0;
         end
      end
   end
   assign out_avg = avg_ff;
   assign out_sum = sum_ff;
   assign out_status = ost_ff;
endmodule
`default_nettype wire

### hw/rtl/iiba_ctrl.sv
// sequencing state machine for loads and queries
`default_nettype none
module iiba_ctrl import iiba_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic in_valid,
   output logic in_ready,
   output logic out_valid,
   input wire logic out_ready,
   input wire dp_status_type stat,
   output ctl_cmd_type cmd
);
   typedef enum logic [7:0] {
      S_IDLE = 8'b00000001,
      S_DEC = 8'b00000010,
      S_LRD = 8'b00000100,
      S_LWR = 8'b00001000,
      S_QRD = 8'b00010000,
      S_QACC = 8'b00100000,
      S_DIV = 8'b01000000,
      S_OUT = 8'b10000000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] sel_ff, sel_in;
   logic valid_ff, valid_in;
   logic [1:0] nxt;
   logic more;

   // next needed corner after the current one
   always_comb begin
      more = 1'b1;
      nxt = sel_ff;
      if (sel_ff == 2'd0 && stat.need_r1) begin
         nxt = 2'd1;
      end else if (sel_ff <= 2'd1 && stat.need_r2) begin
         nxt = 2'd2;
      end else if (sel_ff <= 2'd2 && stat.need_r3) begin
         nxt = 2'd3;
      end else begin
         more = 1'b0;
      end
   end

   assign in_ready = state_ff == S_IDLE;
   assign out_valid = valid_ff;

   always_comb begin
      state_in = state_ff;
      sel_in = sel_ff;
      valid_in = valid_ff && !out_ready;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.capture = in_valid;
            if (in_valid) begin
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            sel_in = 2'd0;
            if (stat.is_query) begin
               cmd.rd_en = 1'b1;
               cmd.rd_sel = 2'd0;
               state_in = stat.query_err ? S_QACC : S_QACC;
            end else begin
               if (stat.load_skip) begin
                  cmd.acc_en = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  cmd.rd_en = 1'b1;
                  state_in = S_LRD;
               end
            end
         end
         S_LRD: begin
            state_in = S_LWR;
         end
         S_LWR: begin
            cmd.load_wr = 1'b1;
            state_in = S_IDLE;
         end
         S_QACC: begin
            cmd.acc_en = 1'b1;
            cmd.acc_sel = sel_ff;
            if (more && !stat.query_err) begin
               sel_in = nxt;
               state_in = S_QRD;
            end else begin
               cmd.div_start = 1'b1;
               state_in = S_DIV;
            end
         end
         S_QRD: begin
            cmd.rd_en = 1'b1;
            cmd.rd_sel = sel_ff;
            state_in = S_QACC;
         end
         S_DIV: begin
            if (stat.div_done && !valid_ff) begin
               cmd.out_load = 1'b1;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sel_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff <= sel_in;
         valid_ff <= valid_in;
      end
   end
endmodule
`default_nettype wire

### hw/rtl/integral_image_box_average_core.sv
// top level of the integral image box average core
// loads step through accept, decode with read of entry above, read wait and write
// queries read the needed corners one by one through the single table port, then
// divide (the divider stays idle on an error status) and present the result
// results wait in an output register; a new item is taken once the result is loaded
// reset is synchronous: row_length 256, no image, load position (0,0), table not cleared
`default_nettype none
module integral_image_box_average_core import iiba_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   output logic req_tready,
   // operation, first_pixel, pixel_value, start_row, start_col, end_row,
   // end_col, rect_width, rect_height (zero padded)
   input wire logic [63:0] req_tdata,
   output logic rsp_tvalid,
   input wire logic rsp_tready,
   // box_average, box_sum, status (zero padded)
   output logic [55:0] rsp_tdata,
   input wire logic csr_psel,
   input wire logic csr_penable,
   input wire logic csr_pwrite,
   input wire logic [1:0] csr_paddr,
   input wire logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   ctl_cmd_type cmd;
   dp_status_type stat;
   logic [8:0] row_length;
   logic [23:0] avg, sum;
   logic [1:0] st;
   logic cfg_wr;

   assign csr_pready = 1'b1;
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite && csr_paddr == 2'd0;
   assign csr_prdata = (csr_paddr == 2'd0) ? {23'd0, row_length} : 32'd0;

   iiba_ctrl u_ctrl (
      .clock(clock), .reset(reset), .in_valid(req_tvalid), .in_ready(req_tready),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .stat(stat), .cmd(cmd)
   );

   iiba_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat), .item(req_tdata[57:0]),
      .cfg_wr(cfg_wr), .cfg_data(csr_pwdata[8:0]), .row_length(row_length),
      .out_avg(avg), .out_sum(sum), .out_status(st)
   );

   assign rsp_tdata = {6'd0, st, sum, avg};
endmodule
`default_nettype wire

### hw/rtl/iiba_checker.sv
// port level checks for the integral image box average core
`default_nettype none
module iiba_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   input wire logic req_tready,
   input wire logic rsp_tvalid,
   input wire logic rsp_tready,
   input wire logic [55:0] rsp_tdata
);
   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)) else $error("rsp hold");
   // no input taken the cycle after a transfer in
   a_seq: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready) else $error("busy");
   // error status carries zero values
   a_err: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[49:48] != 2'd0 |-> rsp_tdata[47:0] == 48'd0)
      else $error("err data");
   // nothing valid out of reset
   a_rst: assert property (@(posedge clock) reset |=> !rsp_tvalid) else $error("reset");
endmodule
bind integral_image_box_average_core iiba_checker u_chk (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
`default_nettype wire

### tb/tb_integral_image_box_average_core.sv
// self-checking testbench for the integral image box average core
module tb_integral_image_box_average_core;
   import iiba_pkg::*;

   localparam int CycleLimit = 1000000;
   localparam int HoldCycles = 400;
   localparam int IdleWait = 60;

   typedef struct packed {
      logic [1:0] status;
      logic [23:0] sum;
      logic [23:0] avg;
   } box_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [63:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   integral_image_box_average_core i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // shadow of the summed-area table and load position
   logic [23:0] sat_table [0:MaxRows*MaxCols-1];
   logic [15:0] sat_row_sum;
   int unsigned sat_row;
   int unsigned sat_col;
   logic sat_image_ok;
   logic [8:0] sat_row_length;

   logic [63:0] pending_items[$];
   box_result_type expected_boxes[$];
   int fail_count = 0;
   int cycle_count = 0;
   logic req_taken = 1'b0;
   logic quiet = 1'b0;
   int hold_requests = 0;
   int holds_done = 0;
   int req_gap = 0;
   int rsp_gap = 0;
   int rsp_hold = 0;

   // stimulus generator view of the load position
   int unsigned gen_row;
   int unsigned gen_col;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned effective_length();
      if (sat_row_length == 0) return 1;
      if (sat_row_length > MaxCols) return MaxCols;
      return sat_row_length;
   endfunction

   function automatic logic [23:0] corner(int unsigned r, int unsigned c);
      return sat_table[(r * MaxCols + c) % (MaxRows * MaxCols)];
   endfunction

   // apply one accepted item to the shadow state; queries yield an expected result
   task automatic predict_item(input logic [63:0] d);
      logic [7:0] sr, sc, er, ec;
      int unsigned area, rl;
      logic [23:0] above, box;
      logic [31:0] scaled;
      box_result_type res;
      sr = d[17:10];
      sc = d[25:18];
      er = d[33:26];
      ec = d[41:34];
      area = d[49:42] * d[57:50];
      rl = effective_length();
      if (d[0] == OP_LOAD) begin
         if (d[1]) begin
            sat_row = 0;
            sat_col = 0;
            sat_row_sum = '0;
         end
         if (sat_row < MaxRows && sat_col < rl) begin
            if (sat_col == 0) sat_row_sum = '0;
            sat_row_sum = sat_row_sum + d[9:2];
            above = (sat_row > 0) ? corner(sat_row - 1, sat_col) : '0;
            sat_table[sat_row * MaxCols + sat_col] = 24'(sat_row_sum) + above;
            sat_image_ok = 1'b1;
            sat_col++;
            if (sat_col >= rl) begin
               sat_col = 0;
               sat_row++;
            end
         end
         return;
      end
      res = '0;
      if (!sat_image_ok) begin
         res.status = STATUS_NO_IMAGE;
      end else if (sr > er || sc > ec || ec >= rl ||
                   !(er < sat_row || (er == sat_row && ec < sat_col))) begin
         res.status = STATUS_OUTSIDE;
      end else if (area == 0) begin
         res.status = STATUS_ZERO_AREA;
      end else begin
         box = corner(er, ec);
         if (sr > 0) box = box - corner(sr - 1, ec);
         if (sc > 0) box = box - corner(er, sc - 1);
         if (sr > 0 && sc > 0) box = box + corner(sr - 1, sc - 1);
         scaled = ({8'd0, box} << 8) / area;
         res.status = STATUS_OK;
         res.sum = box;
         res.avg = (scaled > 32'hFFFFFF) ? 24'hFFFFFF : scaled[23:0];
      end
      expected_boxes.push_back(res);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want,
               cycle_count);
      fail_count++;
   endtask

   // monitor: transfers on both channels, and the cycle limit
   always @(posedge clock) begin
      box_result_type got, want;
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Regression FAIL");
         $finish;
      end else if (!reset) begin
         req_taken = req_tvalid && req_tready;
         if (req_taken) predict_item(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[49:0];
            if (expected_boxes.size() == 0) begin
               report_mismatch("unexpected result", got.status, 0);
            end else begin
               want = expected_boxes.pop_front();
               if (got.avg !== want.avg) report_mismatch("box_average", got.avg, want.avg);
               if (got.sum !== want.sum) report_mismatch("box_sum", got.sum, want.sum);
               if (got.status !== want.status)
                  report_mismatch("status", got.status, want.status);
            end
         end
      end
   end

   // request driver with random idle bursts
   always @(negedge clock) begin
      logic nv;
      logic [63:0] nd;
      nv = req_tvalid;
      nd = req_tdata;
      if (!reset && (!req_tvalid || req_taken)) begin
         nv = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
         end else if (pending_items.size() > 0) begin
            if (!quiet && $urandom_range(0, 7) == 0) begin
               req_gap = $urandom_range(1, 9);
            end else begin
               nv = 1'b1;
               nd = pending_items.pop_front();
            end
         end
         req_taken = 1'b0;
      end
      req_tvalid <= nv;
      req_tdata <= nd;
   end

   // result receiver with stall bursts and one long hold-off
   always @(negedge clock) begin
      logic nr;
      nr = 1'b1;
      if (hold_requests != holds_done) begin
         holds_done = hold_requests;
         rsp_hold = HoldCycles;
      end
      if (rsp_hold > 0) begin
         rsp_hold--;
         nr = 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         nr = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         rsp_gap = $urandom_range(0, 8);
         nr = 1'b0;
      end
      rsp_tready <= reset ? 1'b0 : nr;
   end

   function automatic logic [63:0] load_item(input logic first, input logic [7:0] pix);
      logic [63:0] d;
      d = {$urandom, $urandom};
      d[63:58] = '0;
      d[0] = OP_LOAD;
      d[1] = first;
      d[9:2] = pix;
      return d;
   endfunction

   function automatic logic [63:0] query_item(input logic [7:0] sr, sc, er, ec, w, h);
      logic [63:0] d;
      d = '0;
      d[0] = OP_QUERY;
      d[1] = 1'($urandom_range(0, 1));
      d[9:2] = 8'($urandom);
      d[17:10] = sr;
      d[25:18] = sc;
      d[33:26] = er;
      d[41:34] = ec;
      d[49:42] = w;
      d[57:50] = h;
      return d;
   endfunction

   task automatic wait_idle();
      wait (pending_items.size() == 0 && !req_tvalid && expected_boxes.size() == 0);
      repeat (IdleWait) @(posedge clock);
   endtask

   // two-phase register write, taken only while the core is idle
   task automatic write_row_length(input logic [31:0] value);
      wait_idle();
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= '0;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      sat_row_length = value[8:0];
      sat_image_ok = 1'b0;
      sat_row = 0;
      sat_col = 0;
      sat_row_sum = '0;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // random image loads mixed with queries; most queries land inside the loaded area
   task automatic random_phase(input int unsigned rl, input int n, input int q_pct,
                               input bit bright);
      logic [7:0] sr, sc, er, ec, w, h, pix;
      int unsigned er_top, ec_top;
      logic first;
      gen_row = 0;
      gen_col = 0;
      for (int i = 0; i < n; i++) begin
         if (i > 0 && $urandom_range(0, 99) < q_pct) begin
            if ((gen_row == 0 && gen_col == 0) || $urandom_range(0, 99) < 15) begin
               pending_items.push_back(query_item(8'($urandom), 8'($urandom),
                                                  8'($urandom), 8'($urandom),
                                                  8'($urandom), 8'($urandom)));
            end else begin
               er_top = (gen_col == 0) ? gen_row - 1 : gen_row;
               if (er_top > 255) er_top = 255;
               er = 8'($urandom_range(0, er_top));
               ec_top = (er < gen_row) ? rl - 1 : gen_col - 1;
               ec = 8'($urandom_range(0, ec_top));
               sr = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, er));
               sc = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, ec));
               w = ($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
               h = ($urandom_range(0, 3) == 0) ? 8'd1 : 8'($urandom_range(0, 255));
               pending_items.push_back(query_item(sr, sc, er, ec, w, h));
            end
         end else begin
            first = (i == 0) || ($urandom_range(0, 99) < 2);
            pix = bright ? 8'hFF : 8'($urandom);
            if (first) begin
               gen_row = 0;
               gen_col = 0;
            end
            if (gen_row < MaxRows) begin
               gen_col++;
               if (gen_col >= rl) begin
                  gen_col = 0;
                  gen_row++;
               end
            end
            pending_items.push_back(load_item(first, pix));
         end
      end
   endtask

   initial begin
      sat_row_sum = '0;
      sat_row = 0;
      sat_col = 0;
      sat_image_ok = 1'b0;
      sat_row_length = 9'd256;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: corners, error codes and restart on the reset row length
      pending_items.push_back(query_item(0, 0, 0, 0, 1, 1));
      pending_items.push_back(load_item(1'b1, 8'hFF));
      pending_items.push_back(load_item(1'b0, 8'h00));
      pending_items.push_back(load_item(1'b0, 8'h80));
      pending_items.push_back(load_item(1'b0, 8'hFF));
      pending_items.push_back(query_item(0, 0, 0, 3, 4, 1));
      pending_items.push_back(query_item(0, 1, 0, 3, 3, 1));
      pending_items.push_back(query_item(0, 3, 0, 3, 1, 1));
      pending_items.push_back(query_item(0, 2, 0, 1, 1, 1));
      pending_items.push_back(query_item(1, 0, 0, 0, 1, 1));
      pending_items.push_back(query_item(0, 0, 0, 4, 5, 1));
      pending_items.push_back(query_item(0, 0, 1, 0, 1, 2));
      pending_items.push_back(query_item(0, 0, 0, 3, 0, 1));
      pending_items.push_back(query_item(0, 0, 0, 3, 4, 0));
      pending_items.push_back(query_item(0, 0, 0, 3, 255, 255));
      pending_items.push_back(query_item(255, 255, 255, 255, 255, 255));
      pending_items.push_back(load_item(1'b1, 8'h01));
      pending_items.push_back(query_item(0, 1, 0, 1, 1, 1));
      pending_items.push_back(query_item(0, 0, 0, 0, 1, 1));

      // zero row length acts as one
      write_row_length(32'd0);
      pending_items.push_back(query_item(0, 0, 0, 0, 1, 1));
      random_phase(1, 60, 8, 1'b0);

      // oversize row length acts as the full width
      write_row_length(32'h1FF);
      pending_items.push_back(query_item(0, 0, 0, 0, 1, 1));
      random_phase(256, 60, 30, 1'b0);

      // bright image large enough to saturate the average
      write_row_length(32'd16);
      for (int i = 0; i < 330; i++) pending_items.push_back(load_item(i == 0, 8'hFF));
      pending_items.push_back(query_item(0, 0, 19, 15, 1, 1));
      pending_items.push_back(query_item(0, 0, 19, 15, 255, 255));
      pending_items.push_back(query_item(1, 1, 20, 9, 2, 3));

      // long result hold-off while items keep coming
      write_row_length(32'd5);
      hold_requests++;
      random_phase(5, 120, 60, 1'b0);

      // final stretch without idling
      write_row_length(32'd256);
      wait_idle();
      quiet = 1'b1;
      random_phase(256, 60, 35, 1'b0);

      wait_idle();
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
